// File: sv/imsh_pkg.sv
// shared widths, register indexes and the result item type of the sharpen filter
package imsh_pkg;

   // payload field widths
   localparam int PIX_W        = 8;
   localparam int OUT_COL_W    = 11;
   localparam int OUT_ROW_W    = 12;
   localparam int RSP_DATA_W   = 32;

   // configuration register widths and port shape
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 13;

   // configuration register reset values
   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // result queue shape
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // one result item
   typedef struct packed {
      logic [PIX_W-1:0]     pixel;
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
      logic                 last;
   } rsp_item_type;

endpackage

// File: sv/image_sharpen_3x3_top.sv
// 3x3 laplacian sharpen filter over a raster pixel stream, with two line memories
//
// Usage:
//   req_* carries one 8-bit grey source pixel per item, frame in raster order.
//   rsp_* carries result items: sharpened pixel, its column and row in tdata,
//   and tlast high on the final pixel of the frame.
//   csr_* writes image_width (index 0) and image_height (index 1) while idle.
// An input on row y yields the result for row y-1; the first row gives no
// result, and each input on the last row also yields its own border copy, so
// that row delivers two result items per input item.
// Throughput: one item per cycle while req_tready is high. Each accepted item
// does one read-modify-write of both line memories; the memory reads for the
// next column are issued at the accept edge, so the next item may follow in
// the next cycle. On the last row the output drains one item per cycle while
// rsp_tready is high, so input there is throttled by the result queue.
// Results of an accepted item are written into a four-entry result queue and
// reach rsp_* in the next cycle if it was empty; the queue holds them while
// rsp_tready is low. req_tready drops when fewer than two entries are free.
// Reset clears the position counters, the queue and the size registers
// (640 x 480); line memory contents are undefined until written. req_tready
// stays low for one cycle after reset and after each csr write.
module image_sharpen_3x3_top
   import imsh_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [7:0] pixel_in
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] pixel_out, [18:8] out_col,
                                              // [30:19] out_row, [31] zero
   output logic                  rsp_tlast,   // frame_last
   // configuration port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WSZ_W = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
   localparam int HSZ_W = (ROW_W + 1 > CFG_HEIGHT_W) ? ROW_W + 1 : CFG_HEIGHT_W;

   // configuration registers
   logic [CFG_WIDTH_W-1:0]  image_width_ff;
   logic [CFG_HEIGHT_W-1:0] image_height_ff;
   logic                    hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         hold_ff         <= 1'b1;
      end else begin
         hold_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[CFG_WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // effective frame size: zero acts as one, oversize saturates
   logic [WSZ_W-1:0] w_eff;
   logic [HSZ_W-1:0] h_eff;

   always_comb begin
      if (image_width_ff == '0)
         w_eff = WSZ_W'(1);
      else if (WSZ_W'(image_width_ff) > WSZ_W'(MAX_WIDTH))
         w_eff = WSZ_W'(MAX_WIDTH);
      else
         w_eff = WSZ_W'(image_width_ff);
      if (image_height_ff == '0)
         h_eff = HSZ_W'(1);
      else if (HSZ_W'(image_height_ff) > HSZ_W'(MAX_HEIGHT))
         h_eff = HSZ_W'(MAX_HEIGHT);
      else
         h_eff = HSZ_W'(image_height_ff);
   end

   // position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] cur_col, col_next;
   logic [ROW_W-1:0] cur_row, row_next;
   logic [HSZ_W-1:0] row_wrap;
   logic [WSZ_W-1:0] col_step;
   logic [HSZ_W-1:0] row_step;
   logic             accept;

   assign accept = req_tvalid && req_tready;

   // position of the pending item, wrapped against the current size
   always_comb begin
      if (WSZ_W'(col_ff) >= w_eff) begin
         cur_col  = '0;
         row_wrap = HSZ_W'(row_ff) + 1'b1;
      end else begin
         cur_col  = col_ff;
         row_wrap = HSZ_W'(row_ff);
      end
      cur_row = (row_wrap >= h_eff) ? '0 : row_wrap[ROW_W-1:0];
   end

   // position after the pending item
   always_comb begin
      col_step = WSZ_W'(cur_col) + 1'b1;
      row_step = HSZ_W'(cur_row) + 1'b1;
      if (col_step >= w_eff) begin
         col_next = '0;
         row_next = (row_step >= h_eff) ? '0 : row_step[ROW_W-1:0];
      end else begin
         col_next = col_step[COL_W-1:0];
         row_next = cur_row;
      end
      col_in = accept ? col_next : col_ff;
      row_in = accept ? row_next : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line memories: prev holds the row above, older the row two above
   logic [PIX_W-1:0] prev_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] older_mem [MAX_WIDTH];
   logic [PIX_W-1:0] prev_c_ff, prev_c1_ff, older_c_ff, left_ff;
   logic [COL_W-1:0] rd_addr, rd_addr1;

   // prefetch the column of the next item, bypassing this cycle's write
   assign rd_addr  = accept ? col_next : cur_col;
   assign rd_addr1 = (rd_addr == COL_W'(MAX_WIDTH - 1)) ? '0 : rd_addr + 1'b1;

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_mem[cur_col]  <= req_tdata;
         older_mem[cur_col] <= prev_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      prev_c_ff  <= (accept && cur_col == rd_addr)  ? req_tdata : prev_mem[rd_addr];
      prev_c1_ff <= (accept && cur_col == rd_addr1) ? req_tdata : prev_mem[rd_addr1];
      older_c_ff <= (accept && cur_col == rd_addr)  ? prev_c_ff : older_mem[rd_addr];
   end

   // centre of the previous item is the left neighbour of this one
   always_ff @(posedge clock) begin
      if (accept)
         left_ff <= prev_c_ff;
   end

   // sharpen kernel with clamp
   logic [11:0]      sharp_sum;
   logic [PIX_W-1:0] sharp_pix;
   logic             last_col, border, has_a, has_b;

   always_comb begin
      sharp_sum = {2'b0, prev_c_ff, 2'b0} + {4'b0, prev_c_ff}
                - {4'b0, older_c_ff} - {4'b0, req_tdata}
                - {4'b0, left_ff} - {4'b0, prev_c1_ff};
      if (sharp_sum[11])
         sharp_pix = '0;
      else if (sharp_sum[10:8] != 3'b0)
         sharp_pix = '1;
      else
         sharp_pix = sharp_sum[7:0];
      last_col = (WSZ_W'(cur_col) == w_eff - 1'b1);
      border   = (cur_col == '0) || last_col || (cur_row == ROW_W'(1));
      has_a    = (cur_row != '0);
      has_b    = (HSZ_W'(cur_row) == h_eff - 1'b1);
   end

   rsp_item_type item_a, item_b;

   always_comb begin
      item_a.pixel = border ? prev_c_ff : sharp_pix;
      item_a.col   = OUT_COL_W'(cur_col);
      item_a.row   = OUT_ROW_W'(cur_row - 1'b1);
      item_a.last  = 1'b0;
      item_b.pixel = req_tdata;
      item_b.col   = OUT_COL_W'(cur_col);
      item_b.row   = OUT_ROW_W'(cur_row);
      item_b.last  = last_col;
   end

   // result queue
   rsp_item_type            fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_b;
   logic [FIFO_CNT_W-1:0]   cnt_ff, cnt_in, push_n;
   logic                    pop;

   assign pop      = rsp_tvalid && rsp_tready;
   assign push_n   = accept ? (FIFO_CNT_W'(has_a) + FIFO_CNT_W'(has_b)) : '0;
   assign wr_ptr_b = wr_ptr_ff + FIFO_PTR_W'(has_a);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n[FIFO_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      cnt_in    = cnt_ff + push_n - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_a)
         fifo_mem[wr_ptr_ff] <= item_a;
      if (accept && has_b)
         fifo_mem[wr_ptr_b] <= item_b;
   end

   // channel outputs
   rsp_item_type head;

   assign head       = fifo_mem[rd_ptr_ff];
   assign req_tready = !hold_ff && (cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = {1'b0, head.row, head.col, head.pixel};
   assign rsp_tlast  = head.last;

   // checks
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_hold_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("item accepted right after a csr write");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < (COL_W + 1)'(MAX_WIDTH))
      else $error("column counter beyond line memory");

   a_double_last_row: assert property (@(posedge clock) disable iff (reset)
      (accept && has_a && has_b) |=> (cnt_ff >= FIFO_CNT_W'(2 - 1)) && rsp_tvalid)
      else $error("double result lost");

endmodule
